@@ rtl/dmd_pkg.sv @@
// Shared types and constants for the multi-channel deadline debouncer.
package dmd_pkg;

  localparam int CFG_COUNT  = 8;
  localparam int CFG_W      = 10;
  localparam int CH_FIELD_W = 3;

  typedef logic [CFG_W-1:0]      cfg_word_t;
  typedef logic [CH_FIELD_W-1:0] ch_field_t;

  localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
    10'd0, 10'd0, 10'd5, 10'd25, 10'd25, 10'd0, 10'd0, 10'd0
  };

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    ch_field_t channel;
    logic      level;
    logic      last;
  } rec_t;

endpackage

@@ rtl/dmd_cfg_regs.sv @@
// Debounce time register file; the countdown load value saturates when TIME_BITS is below CFG_W.
module dmd_cfg_regs import dmd_pkg::*; #(
  parameter int TIME_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  ch_field_t            idx_i,
  input  cfg_word_t            data_i,
  input  ch_field_t            rd_idx_i,
  output logic [TIME_BITS-1:0] load_o
);

  cfg_word_t cfg_q [CFG_COUNT];
  cfg_word_t rd_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
    end else if (we_i) begin
      cfg_q[idx_i] <= data_i;
    end
  end

  assign rd_word = cfg_q[rd_idx_i];

  generate
    if (TIME_BITS >= CFG_W) begin : g_wide
      assign load_o = TIME_BITS'(rd_word);
    end else begin : g_sat
      localparam cfg_word_t TimeMax = CFG_W'((1 << TIME_BITS) - 1);
      assign load_o = (rd_word > TimeMax) ? TIME_BITS'(TimeMax) : rd_word[TIME_BITS-1:0];
    end
  endgenerate

endmodule

@@ rtl/dmd_core.sv @@
// Channel state, tick sequencer with shared decrement unit, and output register.
module dmd_core import dmd_pkg::*; #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  ch_field_t            channel_i,
  input  logic                 raw_level_i,
  input  logic [TIME_BITS-1:0] load_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rec_t                 rec_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] IdxLast = CH_W'(CHANNELS - 1);

  state_e                state_q, state_d;
  logic [CH_W-1:0]       idx_q, idx_d;
  logic [CHANNELS-1:0]   fire_q, fire_d, fire_now, fire_rest;
  logic [CHANNELS-1:0]   stable_q, stable_d;
  logic [CHANNELS-1:0]   seen_q, seen_d;
  logic [CHANNELS-1:0]   armed_q, armed_d;
  logic [TIME_BITS-1:0]  rem_q [CHANNELS];
  logic                  out_valid_q, out_valid_d;
  rec_t                  rec_q, rec_d;

  logic [CH_W-1:0]       ch_sel, rem_addr;
  logic                  ch_ok, out_free, rest_empty, step;
  logic                  rem_wr;
  logic [TIME_BITS-1:0]  rem_rd, rem_dec, rem_wdata;

  assign ch_sel   = channel_i[CH_W-1:0];
  assign ch_ok    = int'(channel_i) < CHANNELS;
  assign rem_addr = (state_q == ST_WALK) ? idx_q : ch_sel;
  assign rem_rd   = rem_q[rem_addr];
  assign rem_dec  = rem_rd - 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  assign fire_rest  = (fire_q >> idx_q) >> 1;
  assign rest_empty = (fire_rest == '0);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      fire_now[i] = seen_q[i] && armed_q[i] && (rem_q[i] == '0);
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    fire_d      = fire_q;
    stable_d    = stable_q;
    seen_d      = seen_q;
    armed_d     = armed_q;
    rem_wr      = 1'b0;
    rem_wdata   = load_i;
    out_valid_d = out_valid_q && !out_ready_i;
    rec_d       = rec_q;
    step        = 1'b0;
    in_ready_o  = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_TICK) begin
            fire_d  = fire_now;
            idx_d   = '0;
            state_d = ST_WALK;
          end else if (ch_ok) begin
            if (!seen_q[ch_sel]) begin
              seen_d[ch_sel]   = 1'b1;
              stable_d[ch_sel] = raw_level_i;
            end else if (stable_q[ch_sel] == raw_level_i) begin
              armed_d[ch_sel] = 1'b0;
            end else if (!armed_q[ch_sel]) begin
              armed_d[ch_sel] = 1'b1;
              rem_wr          = 1'b1;
              rem_wdata       = load_i;
            end
          end
        end
      end
      ST_WALK: begin
        if (fire_q[idx_q]) begin
          if (out_free) begin
            stable_d[idx_q] = !stable_q[idx_q];
            armed_d[idx_q]  = 1'b0;
            out_valid_d     = 1'b1;
            rec_d.channel   = CH_FIELD_W'(idx_q);
            rec_d.level     = !stable_q[idx_q];
            rec_d.last      = rest_empty;
            step            = 1'b1;
          end
        end else begin
          if (seen_q[idx_q] && armed_q[idx_q]) begin
            rem_wr    = 1'b1;
            rem_wdata = rem_dec;
          end
          step = 1'b1;
        end
        if (step) begin
          if (idx_q == IdxLast) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      fire_q      <= '0;
      stable_q    <= '0;
      seen_q      <= '0;
      armed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fire_q      <= fire_d;
      stable_q    <= stable_d;
      seen_q      <= seen_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    if (rem_wr) begin
      rem_q[rem_addr] <= rem_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rec_o       = rec_q;

endmodule

@@ rtl/multi_channel_deadline_debouncer.sv @@
// Top level of the multi-channel deadline debouncer.
// Sample transaction: ready again on the next cycle, no change record.
// Tick transaction: busy after acceptance, one channel per cycle through the shared
//   decrement unit in order, stalling while a record waits on a full output register.
// Change records leave through a one-entry output register, one cycle after their channel.
// Reset: all channels unseen and disarmed, debounce times to their defaults.
module multi_channel_deadline_debouncer import dmd_pkg::*; #(
  parameter int CHANNELS  = 8,
  parameter int TIME_BITS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      opcode_i,
  input  ch_field_t channel_i,
  input  logic      raw_level_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ch_field_t changed_channel_o,
  output logic      new_level_o,
  output logic      last_o,
  input  logic      cfg_we_i,
  input  ch_field_t cfg_idx_i,
  input  cfg_word_t cfg_data_i
);

  logic [TIME_BITS-1:0] load;
  rec_t                 rec;

  dmd_cfg_regs #(
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (cfg_we_i),
    .idx_i    (cfg_idx_i),
    .data_i   (cfg_data_i),
    .rd_idx_i (channel_i),
    .load_o   (load)
  );

  dmd_core #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .channel_i   (channel_i),
    .raw_level_i (raw_level_i),
    .load_i      (load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec)
  );

  assign changed_channel_o = rec.channel;
  assign new_level_o       = rec.level;
  assign last_o            = rec.last;

endmodule

@@ rtl/dmd_checker.sv @@
// Port-level assertions for the debouncer and their bind to the top level.
module dmd_checker import dmd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      opcode_i,
  input ch_field_t channel_i,
  input logic      raw_level_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input ch_field_t changed_channel_o,
  input logic      new_level_o,
  input logic      last_o,
  input logic      cfg_we_i,
  input ch_field_t cfg_idx_i,
  input cfg_word_t cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(changed_channel_o)
      && $stable(new_level_o) && $stable(last_o))
    else $error("output record changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_TICK |=> !in_ready_o)
    else $error("ready while walking channels after a tick");

  a_sample_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_SAMPLE |=> in_ready_o)
    else $error("sample transaction left the block busy");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("tick walk ended before its last record");

endmodule

bind multi_channel_deadline_debouncer dmd_checker u_dmd_checker (.*);
